>>> sv/mhfs_pkg.sv
// Package for the MP3 header frame size parser.
// Holds the item and result structs, the parse phase type, codes and tables.
// No dependencies.
package mhfs_pkg;

  // Width of the saturating byte offset counter.
  localparam int OFFSET_BITS = 32;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  localparam offset_t OFFSET_MAX = '1;

  localparam logic [7:0] ID3_CHAR_I = 8'h49;
  localparam logic [7:0] ID3_CHAR_D = 8'h44;
  localparam logic [7:0] ID3_CHAR_3 = 8'h33;

  localparam logic [28:0] TAG_HEADER_LEN = 29'd10;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'd255;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'd251;

  // Result status codes.
  localparam logic [1:0] STATUS_FRAME    = 2'd0;
  localparam logic [1:0] STATUS_RESERVED = 2'd1;
  localparam logic [1:0] STATUS_NO_SYNC  = 2'd2;

  // Register indexes on the configuration port (word address bit 2).
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef enum logic [2:0] {
    PH_CHECK,
    PH_HEAD,
    PH_SKIP,
    PH_SEARCH0,
    PH_SEARCH,
    PH_HEADER,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [28:0] tag_bytes;
    logic [31:0] sync_offset;
    logic [10:0] frame_bytes;
  } result_t;

  // floor(144 * bitrate / samplerate) for each bitrate index and sample rate.
  localparam logic [10:0] FRAME_44K1 [16] = '{
    11'd0,   11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
    11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0
  };
  localparam logic [10:0] FRAME_48K [16] = '{
    11'd0,   11'd96,  11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
    11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0
  };
  localparam logic [10:0] FRAME_32K [16] = '{
    11'd0,   11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
    11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0
  };

  function automatic logic [10:0] frame_len(input logic [3:0] bi, input logic [1:0] si);
    logic [10:0] len;
    case (si)
      2'd0:    len = FRAME_44K1[bi];
      2'd1:    len = FRAME_48K[bi];
      2'd2:    len = FRAME_32K[bi];
      default: len = 11'd0;
    endcase
    return len;
  endfunction

  // Expected tag identifier byte at file offsets zero to two.
  function automatic logic [7:0] id3_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = ID3_CHAR_I;
      2'd1:    c = ID3_CHAR_D;
      default: c = ID3_CHAR_3;
    endcase
    return c;
  endfunction

  // Clamps an offset to the 32-bit range of the sync_offset field.
  function automatic logic [31:0] sat32(input offset_t v);
    logic [31:0] r;
    if ((v >> 32) != '0) begin
      r = '1;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

>>> sv/mp3_header_frame_size_parser.sv
// Top level of the MP3 header frame size parser: ID3v2 tag skip, sync search
// and MPEG-1 Layer III frame length decode. Depends on mhfs_pkg.
//
//  channel   direction  handshake                         payload
//  item      in         item_valid / item_ready           item_t  (data_byte, last_byte)
//  result    out        result_valid / result_ready       result_t (status, tag_bytes,
//                                                                   sync_offset, frame_bytes)
//  config    in         psel, penable, pwrite, pready     paddr[2:0], pwdata, prdata
//
// An item is taken into the input register and parsed at the next edge on which
// the result register is free or being emptied; an item that completes a
// parse writes its result into the result register at that edge.
// A new item is accepted in every cycle while results are taken.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the tag check at offset zero; the sync bytes return to 0xFF and 0xFB.
// A stalled result holds the parse stage; the input register still takes
// one more item behind it.
module mp3_header_frame_size_parser
  import mhfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [7:0] sync_first;
  logic [7:0] sync_second;

  // Input register.
  logic  s1_valid;
  item_t s1_item;

  // Parser state.
  phase_t      phase, phase_next;
  offset_t     byte_offset, byte_offset_next;
  logic [28:0] tag_size_accum, tag_size_accum_next;
  logic [27:0] skip_left, skip_left_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [31:0] sync_position, sync_position_next;

  logic    fire;
  logic    out_free;
  logic    decode_now;
  logic    sync_hit;
  logic    emit;
  result_t result_next;

  logic [7:0]  b;
  logic        off_lt3;
  logic [28:0] accum_shift;
  logic [27:0] skip_dec;
  offset_t     hit_pos;

  // The configuration port never waits; reads return the byte in the low lane.
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_SYNC_SECOND) begin
      prdata = {24'd0, sync_second};
    end else begin
      prdata = {24'd0, sync_first};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SYNC_FIRST) begin
        sync_first <= pwdata[7:0];
      end else begin
        sync_second <= pwdata[7:0];
      end
    end
  end

  // The parse stage moves when the result register is free or being emptied.
  assign out_free   = !result_valid || result_ready;
  assign fire       = s1_valid && out_free;
  assign item_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  assign b        = s1_item.data_byte;
  assign off_lt3  = byte_offset < offset_t'(3);
  assign sync_hit = (previous_byte == sync_first) && (b == sync_second);

  // The first sync byte sits one before the current offset, except when the
  // offset counter is zero or has saturated, where the offset itself is reported.
  assign hit_pos = (byte_offset == OFFSET_MAX || byte_offset == '0) ?
                   byte_offset : byte_offset - offset_t'(1);

  // Synchsafe size: seven new bits a byte, kept to 28 bits.
  assign accum_shift = {1'b0, tag_size_accum[20:0], b[6:0]};
  assign skip_dec    = (skip_left != '0) ? skip_left - 28'd1 : skip_left;

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_CHECK: begin
        if (off_lt3 && b == id3_char(byte_offset[1:0])) begin
          if (byte_offset[1:0] == 2'd2) begin
            phase_next = PH_HEAD;
          end
        end else if (byte_offset == offset_t'(2) && sync_first == ID3_CHAR_I &&
                     sync_second == ID3_CHAR_D) begin
          phase_next = PH_DONE;
        end else if (byte_offset == '0) begin
          phase_next = PH_SEARCH;
        end else if (sync_hit) begin
          phase_next = PH_HEADER;
        end
      end
      PH_HEAD: begin
        if (byte_offset >= offset_t'(9)) begin
          phase_next = (accum_shift[27:0] != '0) ? PH_SKIP : PH_SEARCH0;
        end
      end
      PH_SKIP: begin
        if (skip_dec == '0) begin
          phase_next = PH_SEARCH0;
        end
      end
      PH_SEARCH0: phase_next = PH_SEARCH;
      PH_SEARCH: begin
        if (sync_hit) begin
          phase_next = PH_HEADER;
        end
      end
      PH_HEADER: phase_next = PH_DONE;
      default:   phase_next = phase;
    endcase
    if (s1_item.last_byte) begin
      phase_next = PH_CHECK;
    end
  end

  // Datapath updates and the result for the item in the parse stage.
  always_comb begin
    logic [28:0] tag_now;
    logic        reserved;
    logic [28:0] tag_err;

    previous_byte_next  = previous_byte;
    tag_size_accum_next = tag_size_accum;
    skip_left_next      = skip_left;
    sync_position_next  = sync_position;
    decode_now          = 1'b0;
    tag_now             = tag_size_accum;

    case (phase)
      PH_CHECK: begin
        if (off_lt3 && b == id3_char(byte_offset[1:0])) begin
          if (byte_offset[1:0] == 2'd2) begin
            tag_size_accum_next = '0;
          end else begin
            previous_byte_next = b;
          end
        end else if (byte_offset == offset_t'(2) && sync_first == ID3_CHAR_I &&
                     sync_second == ID3_CHAR_D) begin
          decode_now = 1'b1;
        end else if (byte_offset == '0) begin
          previous_byte_next = b;
        end else if (sync_hit) begin
          sync_position_next = sat32(hit_pos);
        end else begin
          previous_byte_next = b;
        end
      end
      PH_HEAD: begin
        if (byte_offset >= offset_t'(6)) begin
          tag_now = accum_shift;
        end
        if (byte_offset >= offset_t'(9)) begin
          skip_left_next = tag_now[27:0];
          tag_now        = tag_now + TAG_HEADER_LEN;
        end
        tag_size_accum_next = tag_now;
      end
      PH_SKIP: skip_left_next = skip_dec;
      PH_SEARCH0: previous_byte_next = b;
      PH_SEARCH: begin
        if (sync_hit) begin
          sync_position_next = sat32(hit_pos);
        end else begin
          previous_byte_next = b;
        end
      end
      PH_HEADER: decode_now = 1'b1;
      default: ;
    endcase

    // Frame header byte: bitrate index, sample-rate index, padding bit.
    reserved = (b[7:4] inside {4'd0, 4'd15}) || (b[3:2] == 2'd3);
    if (reserved) begin
      result_next.status      = STATUS_RESERVED;
      result_next.frame_bytes = 11'd0;
    end else begin
      result_next.status      = STATUS_FRAME;
      result_next.frame_bytes = frame_len(b[7:4], b[3:2]) + {10'd0, b[1]};
    end
    result_next.tag_bytes   = tag_size_accum;
    result_next.sync_offset = sync_position;

    // End of file without a decoded header gives a no-sync result. The tag
    // length counts only once its header has been read completely.
    emit    = decode_now;
    tag_err = '0;
    if (s1_item.last_byte && phase != PH_DONE && !decode_now) begin
      emit = 1'b1;
      // phase_next is already forced to the tag check on the final byte, so
      // look at where the parse would have gone without it.
      if (phase == PH_CHECK || (phase == PH_HEAD && byte_offset < offset_t'(9))) begin
        tag_err = '0;
      end else begin
        tag_err = tag_size_accum_next;
      end
      result_next.status      = STATUS_NO_SYNC;
      result_next.tag_bytes   = tag_err;
      result_next.sync_offset = 32'd0;
      result_next.frame_bytes = 11'd0;
    end

    byte_offset_next = (byte_offset == OFFSET_MAX) ? byte_offset :
                       byte_offset + offset_t'(1);

    // The final byte of a file rearms the parser.
    if (s1_item.last_byte) begin
      byte_offset_next    = '0;
      tag_size_accum_next = '0;
      previous_byte_next  = '0;
      sync_position_next  = '0;
      skip_left_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CHECK;
      byte_offset    <= '0;
      tag_size_accum <= '0;
      skip_left      <= '0;
      previous_byte  <= '0;
      sync_position  <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      byte_offset    <= byte_offset_next;
      tag_size_accum <= tag_size_accum_next;
      skip_left      <= skip_left_next;
      previous_byte  <= previous_byte_next;
      sync_position  <= sync_position_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= result_next;
    end
  end

endmodule

>>> sv/mhfs_checker.sv
// Port-level checker for the MP3 header frame size parser, bound to the top.
// Depends on mhfs_pkg.
module mhfs_checker
  import mhfs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input result_t     result
);

  // A reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A waiting result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Only a found frame carries a length.
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_FRAME |-> result.frame_bytes == 11'd0)
    else $error("frame length on an error result");

  // The status code stays within its defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status == STATUS_FRAME || result.status == STATUS_RESERVED ||
                     result.status == STATUS_NO_SYNC)
    else $error("undefined status code");

  // A missing sync reports no offset.
  a_nosync_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_NO_SYNC |-> result.sync_offset == 32'd0)
    else $error("sync offset on a no-sync result");

endmodule

bind mp3_header_frame_size_parser mhfs_checker u_mhfs_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for mp3_header_frame_size_parser. It streams whole files into the parser
// one byte per item and checks every report against a frame-length predictor kept here.
// Depends on mhfs_pkg and the parser RTL.
module tb_top
  import mhfs_pkg::*;
();

  // Cycles in which no item and no report moves before the run is declared hung.
  // The longest quiet stretch in a correct run is the deliberate result stall.
  localparam int QUIET_LIMIT = 5000;
  // The parser passes an item through its input register into its result register;
  // this wait leaves margin on top of that path.
  localparam int PIPE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b1;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mp3_header_frame_size_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame-length predictor. It follows the parser's view of the current file:
  // where it stands (tag check, tag header, tag skip, sync hunt, header byte),
  // the running byte offset and whatever has been learned about tag and sync.
  // ---------------------------------------------------------------------------
  logic [7:0]  sync_first_cfg = SYNC_FIRST_RESET;
  logic [7:0]  sync_second_cfg = SYNC_SECOND_RESET;

  phase_t      hunt_phase = PH_CHECK;
  offset_t     file_offset = '0;
  logic [28:0] tag_total = '0;
  logic [7:0]  last_seen_byte = '0;
  offset_t     sync_at = '0;
  bit          frame_reported = 1'b0;
  logic [27:0] skip_remaining = '0;

  logic [7:0]  id3_mark [3] = '{ID3_CHAR_I, ID3_CHAR_D, ID3_CHAR_3};
  // MPEG-1 Layer III bitrates in kbit/s and sample rates in Hz, by header index.
  // Index 0 (free format), index 15 and sample-rate index 3 have no length.
  int unsigned kbps_of_index [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
                                      112, 128, 160, 192, 224, 256, 320, 0};
  int unsigned hz_of_index [4] = '{44100, 48000, 32000, 0};

  result_t     pending_reports [$];
  logic [7:0]  file_buf [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int stall_request = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int live_items = 0;
  int files_sent = 0;
  int reports_predicted = 0;
  int reports_checked = 0;
  int mismatches = 0;

  // Decodes the frame header byte that follows the sync pair and closes the file.
  function automatic result_t header_report(input logic [7:0] hdr);
    result_t         r;
    logic [3:0]      bi;
    logic [1:0]      si;
    longint unsigned len;
    bi = hdr[7:4];
    si = hdr[3:2];
    r.tag_bytes = tag_total;
    r.sync_offset = (sync_at > offset_t'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(sync_at);
    if (bi == 4'd0 || bi == 4'd15 || si == 2'd3) begin
      r.status = STATUS_RESERVED;
      r.frame_bytes = '0;
    end else begin
      // Multiply before dividing so that only one truncation happens.
      len = (64'd144 * kbps_of_index[bi] * 64'd1000) / hz_of_index[si] + hdr[1];
      r.status = STATUS_FRAME;
      r.frame_bytes = 11'(len);
    end
    hunt_phase = PH_DONE;
    frame_reported = 1'b1;
    return r;
  endfunction

  // One step of the sliding sync search over consecutive bytes.
  function automatic void slide_sync(input logic [7:0] b, input offset_t off);
    if (last_seen_byte == sync_first_cfg && b == sync_second_cfg) begin
      if (off == OFFSET_MAX) begin
        sync_at = OFFSET_MAX;
      end else if (off == offset_t'(0)) begin
        sync_at = '0;
      end else begin
        sync_at = off - offset_t'(1);
      end
      hunt_phase = PH_HEADER;
    end else begin
      last_seen_byte = b;
    end
  endfunction

  // Advances the predictor by one accepted file byte. Returns 1 with the
  // expected report in r when this byte causes one.
  function automatic bit parse_file_byte(input logic [7:0] b, input bit last,
                                         output result_t r);
    offset_t off;
    bit      made;
    off = file_offset;
    made = 1'b0;
    r = '0;
    case (hunt_phase)
      PH_CHECK: begin
        if (off < 3 && b == id3_mark[off[1:0]]) begin
          if (off == 2) begin
            hunt_phase = PH_HEAD;
            tag_total = '0;
          end else begin
            last_seen_byte = b;
          end
        end else if (off == 2 && sync_first_cfg == ID3_CHAR_I
                     && sync_second_cfg == ID3_CHAR_D) begin
          // "ID" is itself the sync pair and the third byte is not '3': that
          // byte is the frame header, with the sync at offset zero.
          sync_at = '0;
          r = header_report(b);
          made = 1'b1;
        end else if (off == 0) begin
          last_seen_byte = b;
          hunt_phase = PH_SEARCH;
        end else begin
          // A broken tag identifier still takes part in the sync hunt.
          slide_sync(b, off);
        end
      end
      PH_HEAD: begin
        if (off >= 6) begin
          tag_total = {1'b0, tag_total[20:0], b[6:0]};
        end
        if (off >= 9) begin
          skip_remaining = tag_total[27:0];
          tag_total = tag_total + TAG_HEADER_LEN;
          hunt_phase = (skip_remaining != '0) ? PH_SKIP : PH_SEARCH0;
        end
      end
      PH_SKIP: begin
        if (skip_remaining != '0) begin
          skip_remaining = skip_remaining - 28'd1;
        end
        if (skip_remaining == '0) begin
          hunt_phase = PH_SEARCH0;
        end
      end
      PH_SEARCH0: begin
        last_seen_byte = b;
        hunt_phase = PH_SEARCH;
      end
      PH_SEARCH: begin
        slide_sync(b, off);
      end
      PH_HEADER: begin
        r = header_report(b);
        made = 1'b1;
      end
      default: begin
      end
    endcase

    if (file_offset != OFFSET_MAX) begin
      file_offset = file_offset + offset_t'(1);
    end

    if (last) begin
      if (!frame_reported && !made) begin
        r.status = STATUS_NO_SYNC;
        r.tag_bytes = (hunt_phase == PH_CHECK || hunt_phase == PH_HEAD) ? '0 : tag_total;
        r.sync_offset = '0;
        r.frame_bytes = '0;
        made = 1'b1;
      end
      // The parser rearms for the next file; the sync registers stay.
      hunt_phase = PH_CHECK;
      file_offset = '0;
      tag_total = '0;
      last_seen_byte = '0;
      sync_at = '0;
      frame_reported = 1'b0;
      skip_remaining = '0;
    end
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. One item is one file byte; the sender may pause before it.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input bit last);
    result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!item_ready);
    // Bytes after a report are only waited out by the parser.
    if (hunt_phase != PH_DONE) begin
      live_items++;
    end
    if (parse_file_byte(b, last, r)) begin
      pending_reports.push_back(r);
      reports_predicted++;
    end
  endtask

  // Sends the bytes in file_buf as one file, marking the final byte.
  task automatic stream_file();
    for (int i = 0; i < file_buf.size(); i++) begin
      push_byte(file_buf[i], i == file_buf.size() - 1);
    end
    files_sent++;
  endtask

  // Stops sending and waits until every expected report has arrived. A final
  // byte that reports nothing may still sit in the pipeline, so the task keeps
  // waiting before the caller touches the registers.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port. pready is tied high, so each access is a setup phase and an
  // access phase; the leading edge keeps back-to-back accesses apart.
  // ---------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic idx, input logic [7:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, wdata};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic verify_sync_regs();
    logic [31:0] rd;
    apb_access(1'b0, REG_SYNC_FIRST, 8'h00, rd);
    if (rd[7:0] !== sync_first_cfg) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("sync_first readback: expected %02h, got %02h", sync_first_cfg, rd[7:0]);
      end
    end
    apb_access(1'b0, REG_SYNC_SECOND, 8'h00, rd);
    if (rd[7:0] !== sync_second_cfg) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("sync_second readback: expected %02h, got %02h", sync_second_cfg, rd[7:0]);
      end
    end
  endtask

  task automatic program_sync(input logic [7:0] first, input logic [7:0] second);
    logic [31:0] rd;
    apb_access(1'b1, REG_SYNC_FIRST, first, rd);
    sync_first_cfg = first;
    apb_access(1'b1, REG_SYNC_SECOND, second, rd);
    sync_second_cfg = second;
    verify_sync_regs();
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The receiver stalls at random, or for a long stretch when a
  // test asks for one, and every accepted report is checked in order.
  // ---------------------------------------------------------------------------
  task automatic check_report(input result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected report at %0t: status %0d tag %0d offset %0d frame %0d",
                 $time, got.status, got.tag_bytes, got.sync_offset, got.frame_bytes);
      end
    end else begin
      want = pending_reports.pop_front();
      reports_checked++;
      if (got.status !== want.status || got.tag_bytes !== want.tag_bytes
          || got.sync_offset !== want.sync_offset || got.frame_bytes !== want.frame_bytes) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report mismatch at %0t: expected status %0d tag %0d offset %0d frame %0d",
                   $time, want.status, want.tag_bytes, want.sync_offset, want.frame_bytes);
          $display("                          got status %0d tag %0d offset %0d frame %0d",
                   got.status, got.tag_bytes, got.sync_offset, got.frame_bytes);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      check_report(result);
    end
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: a run in which neither side moves for too long is hung.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: nothing moved for %0d cycles.", QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Random files. Most are well formed: an optional ID3v2 tag of modest size,
  // some leading junk, the sync pair and a header byte with mostly valid
  // indices. The rest miss the sync, stop right after it, or are cut short,
  // and a few carry a huge tag that the file ends inside.
  // ---------------------------------------------------------------------------
  function automatic void build_random_file();
    logic [27:0] size;
    logic [7:0]  hdr;
    bit          huge;
    int unsigned keep;
    file_buf.delete();
    if ($urandom_range(3) == 0) begin
      huge = ($urandom_range(9) == 0);
      if (huge) begin
        size = 28'($urandom);
      end else if ($urandom_range(7) == 0) begin
        size = 28'($urandom_range(200));
      end else begin
        size = 28'($urandom_range(24));
      end
      file_buf.push_back(ID3_CHAR_I);
      file_buf.push_back(ID3_CHAR_D);
      file_buf.push_back(ID3_CHAR_3);
      repeat (3) file_buf.push_back(8'($urandom));
      // Synchsafe size, most significant group first. The spare top bit of
      // each byte is noise that the parser must drop.
      file_buf.push_back({1'($urandom), size[27:21]});
      file_buf.push_back({1'($urandom), size[20:14]});
      file_buf.push_back({1'($urandom), size[13:7]});
      file_buf.push_back({1'($urandom), size[6:0]});
      if (huge) begin
        repeat ($urandom_range(30)) file_buf.push_back(8'($urandom));
        return;
      end
      repeat (size) file_buf.push_back(8'($urandom));
    end
    repeat ($urandom_range(6)) file_buf.push_back(8'($urandom));
    case ($urandom_range(9))
      0: begin
      end
      1: begin
        file_buf.push_back(sync_first_cfg);
      end
      2: begin
        file_buf.push_back(sync_first_cfg);
        file_buf.push_back(sync_second_cfg);
      end
      default: begin
        if ($urandom_range(3) == 0) begin
          hdr = 8'($urandom);
        end else begin
          hdr = {4'($urandom_range(14, 1)), 2'($urandom_range(2)), 2'($urandom)};
        end
        file_buf.push_back(sync_first_cfg);
        file_buf.push_back(sync_second_cfg);
        file_buf.push_back(hdr);
        repeat ($urandom_range(3)) file_buf.push_back(8'($urandom));
      end
    endcase
    if (file_buf.size() == 0) begin
      file_buf.push_back(8'($urandom));
    end
    if ($urandom_range(11) == 0) begin
      keep = $urandom_range(file_buf.size(), 1);
      while (file_buf.size() > keep) void'(file_buf.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-written files: field extremes, both error statuses, ignored
  // trailing bytes, the largest tag, and the two ways the "ID3" prefix can
  // interact with the sync pair.
  task automatic test_directed();
    verify_sync_regs();
    // 320 kbit/s at 32 kHz with padding gives the longest frame.
    file_buf = '{8'hFF, 8'hFB, 8'hEA};
    stream_file();
    // A one-byte file reports a missing sync at once.
    file_buf = '{8'h00};
    stream_file();
    // Bitrate index 15 is reserved; the byte after the report is ignored.
    file_buf = '{8'hFF, 8'hFB, 8'hFF, 8'h55};
    stream_file();
    // Largest synchsafe size, file ends as soon as the tag header is complete.
    file_buf = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h80, 8'h7F, 8'h7F, 8'h7F, 8'hFF};
    stream_file();
    // With "ID" as the sync pair, a third byte other than '3' is the header.
    wait_idle();
    program_sync(ID3_CHAR_I, ID3_CHAR_D);
    file_buf = '{8'h49, 8'h44, 8'h54};
    stream_file();
    // A failed identifier still feeds the hunt: the pair "D", 0x22 sits at offset 1.
    wait_idle();
    program_sync(ID3_CHAR_D, 8'h22);
    file_buf = '{8'h49, 8'h44, 8'h22, 8'hA4};
    stream_file();
  endtask

  task automatic test_random_files(input int tx_pct, input int rx_pct,
                                   input logic [7:0] first, input logic [7:0] second,
                                   input int quota);
    int start_items;
    int start_reports;
    wait_idle();
    program_sync(first, second);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start_items = live_items;
    start_reports = reports_predicted;
    while (live_items - start_items < quota || reports_predicted - start_reports < 8) begin
      build_random_file();
      stream_file();
    end
  endtask

  // Holds the receiver off for a long stretch while one-byte files keep
  // arriving, so each of them wants a report and the input side must stall.
  task automatic test_output_stall();
    wait_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    stall_request = 300;
    repeat (40) begin
      file_buf = '{8'($urandom)};
      stream_file();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_files(0, 0, 8'hFF, 8'hFB, 110);
    test_random_files(70, 0, 8'h00, 8'h00, 110);
    test_output_stall();
    test_random_files(0, 70, 8'hFF, 8'hFF, 110);
    test_random_files(20, 20, 8'h00, 8'hFF, 110);
    test_random_files(0, 0, ID3_CHAR_I, ID3_CHAR_D, 110);
    test_random_files(20, 20, 8'($urandom), 8'($urandom), 110);

    // Everything has been sent; let the last reports drain and give a stray
    // extra report time to show up.
    wait_idle();
    repeat (2 * PIPE_CYCLES) @(posedge clk);

    $display("Streamed %0d files (%0d bytes the parser acted on) under several sync settings.",
             files_sent, live_items);
    $display("Checked %0d reports across idle and stall mixes, one long stall included.",
             reports_checked);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
